[src/skhc_pkg.sv]
// shared constants and types for the string key hash cache
// used by skhc_store, skhc_keybuf and string_key_hash_cache_core; no dependencies
package skhc_pkg;

	// slot count must be a power of two: the probe start is the low hash bits
	localparam int unsigned SLOTS      = 8192;
	localparam int unsigned MAX_UNITS  = 35;
	localparam int unsigned SLOT_W     = $clog2(SLOTS);
	localparam int unsigned CNT_W      = SLOT_W + 1;
	localparam int unsigned LEN_W      = $clog2(MAX_UNITS + 1);
	localparam int unsigned IDX_W      = $clog2(MAX_UNITS);
	localparam int unsigned KEY_DEPTH  = SLOTS * MAX_UNITS;
	localparam int unsigned KEY_AW     = $clog2(KEY_DEPTH);
	localparam int unsigned UNIT_W     = 16;
	localparam int unsigned HANDLE_W   = 32;
	localparam int unsigned HASH_W     = 32;

	localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
	localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

	localparam logic [CNT_W-1:0] THR_RESET = CNT_W'(6144);

	// command codes
	localparam logic [1:0] CMD_FIND      = 2'd0;
	localparam logic [1:0] CMD_INS_EVICT = 2'd1;
	localparam logic [1:0] CMD_INS_KEEP  = 2'd2;
	localparam logic [1:0] CMD_CLEAR     = 2'd3;

	// register index of evict_threshold (paddr[2])
	localparam logic REG_EVICT_THR = 1'b0;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot_addr;
		logic                valid_we;
		logic                valid_wd;
		logic                slot_we;
		logic [HANDLE_W-1:0] value_wd;
		logic [LEN_W-1:0]    len_wd;
		logic [KEY_AW-1:0]   key_addr;
		logic                key_we;
		logic [UNIT_W-1:0]   key_wd;
	} store_req_t;

	typedef struct packed {
		logic                valid;
		logic [HANDLE_W-1:0] value;
		logic [LEN_W-1:0]    len;
		logic [UNIT_W-1:0]   key;
	} store_rsp_t;

endpackage

[src/skhc_store.sv]
// slot memories: valid bit, handle, key length and key units
// depends on skhc_pkg
module skhc_store (
	input  logic                 clk,
	input  skhc_pkg::store_req_t req,
	output skhc_pkg::store_rsp_t rsp
);

	logic                          valid_mem [skhc_pkg::SLOTS];
	logic [skhc_pkg::HANDLE_W-1:0] value_mem [skhc_pkg::SLOTS];
	logic [skhc_pkg::LEN_W-1:0]    len_mem   [skhc_pkg::SLOTS];
	logic [skhc_pkg::UNIT_W-1:0]   key_mem   [skhc_pkg::KEY_DEPTH];

	always_ff @(posedge clk) begin
		if (req.valid_we) begin
			valid_mem[req.slot_addr] <= req.valid_wd;
		end
		rsp.valid <= valid_mem[req.slot_addr];
	end

	always_ff @(posedge clk) begin
		if (req.slot_we) begin
			value_mem[req.slot_addr] <= req.value_wd;
			len_mem[req.slot_addr]   <= req.len_wd;
		end
		rsp.value <= value_mem[req.slot_addr];
		rsp.len   <= len_mem[req.slot_addr];
	end

	always_ff @(posedge clk) begin
		if (req.key_we) begin
			key_mem[req.key_addr] <= req.key_wd;
		end
		rsp.key <= key_mem[req.key_addr];
	end

endmodule

[src/skhc_keybuf.sv]
// pending key buffer with running fnv-1a hash, length and overflow flag
// depends on skhc_pkg
module skhc_keybuf (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [skhc_pkg::UNIT_W-1:0]       unit,
	input  logic                              restart,
	input  logic [skhc_pkg::IDX_W-1:0]        rd_idx,
	output logic [skhc_pkg::HASH_W-1:0]       hash,
	output logic [skhc_pkg::LEN_W-1:0]        len,
	output logic                              overflow,
	output logic [skhc_pkg::UNIT_W-1:0]       rd_unit
);

	logic [skhc_pkg::UNIT_W-1:0] buf_mem [skhc_pkg::MAX_UNITS];
	logic [skhc_pkg::HASH_W-1:0] hash_q;
	logic [skhc_pkg::LEN_W-1:0]  len_q;
	logic                        ovf_q;
	logic [skhc_pkg::HASH_W-1:0] mixed;
	logic [skhc_pkg::HASH_W-1:0] hash_next;
	logic                        room;

	assign mixed     = hash_q ^ {{(skhc_pkg::HASH_W - skhc_pkg::UNIT_W){1'b0}}, unit};
	assign hash_next = mixed * skhc_pkg::FNV_PRIME;
	assign room      = len_q < skhc_pkg::LEN_W'(skhc_pkg::MAX_UNITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= skhc_pkg::FNV_BASIS;
			len_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (restart) begin
			hash_q <= skhc_pkg::FNV_BASIS;
			len_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (load) begin
			hash_q <= hash_next;
			if (room) begin
				len_q <= len_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && room) begin
			buf_mem[len_q[skhc_pkg::IDX_W-1:0]] <= unit;
		end
		rd_unit <= buf_mem[rd_idx];
	end

	assign hash     = hash_q;
	assign len      = len_q;
	assign overflow = ovf_q;

endmodule

[src/string_key_hash_cache_core.sv]
// top level of the string key hash cache: stream ports, apb register, probe sequencer
// depends on skhc_pkg, skhc_store and skhc_keybuf

// Keys arrive one 16-bit unit per request on the slave stream. On the last unit the
// sequencer acts on the command, with one shared compare path over the slot memories:
// a decide step, a read and a check per probed slot, plus a read and a check per key
// unit compared on a slot of equal length, a settle step on a miss, then on an insert
// a step to claim the slot and a read and a write per unit copied, then the done state,
// which hands the result to the output register once the previous result has left it.
// A clear command, or an evicting insert that misses once the used count has reached
// the threshold, sweeps the valid memory, one slot per cycle; the same sweep runs
// after reset, and no request is taken until it ends. A result waits in the output
// register while further non-last units are taken.
module string_key_hash_cache_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // key_unit[15:0], handle[47:16]
	input  logic [1:0]  s_tuser,   // command[1:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // hit[0], found_handle[32:1], stored[33],
	                               // table_cleared[34], key_rejected[35], entries_used[49:36]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_DECIDE, ST_P_RD, ST_P_CHK, ST_C_RD, ST_C_CHK,
		ST_MISS, ST_INS, ST_CP_RD, ST_CP_WR, ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		AFT_NONE, AFT_RESULT, AFT_INSERT
	} after_t;

	state_t                         state_q;
	after_t                         after_q;
	logic [skhc_pkg::SLOT_W-1:0]    clr_cnt_q;
	logic [skhc_pkg::SLOT_W-1:0]    slot_q;
	logic [skhc_pkg::SLOT_W-1:0]    start_q;
	logic [skhc_pkg::SLOT_W-1:0]    slot_nxt;
	logic [skhc_pkg::KEY_AW-1:0]    base_q;
	logic [skhc_pkg::IDX_W-1:0]     idx_q;
	logic [skhc_pkg::CNT_W-1:0]     used_q;
	logic [skhc_pkg::CNT_W-1:0]     thr_q;
	logic [1:0]                     cmd_q;
	logic [skhc_pkg::HANDLE_W-1:0]  handle_q;
	logic [skhc_pkg::HANDLE_W-1:0]  found_q;
	logic                           empty_q;
	logic                           res_hit_q;
	logic [skhc_pkg::HANDLE_W-1:0]  res_found_q;
	logic                           res_stored_q;
	logic                           res_cleared_q;
	logic                           res_rej_q;
	logic                           m_tvalid_q;
	logic [55:0]                    m_tdata_q;

	logic                           s_accept;
	logic                           cfg_wr;
	logic                           last_idx;
	logic                           restart;
	skhc_pkg::store_req_t           sreq;
	skhc_pkg::store_rsp_t           srsp;
	logic [skhc_pkg::HASH_W-1:0]    hash;
	logic [skhc_pkg::LEN_W-1:0]     pend_len;
	logic                           pend_ovf;
	logic [skhc_pkg::UNIT_W-1:0]    pend_unit;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready &&
	                  (paddr[2] == skhc_pkg::REG_EVICT_THR);
	assign prdata   = (paddr[2] == skhc_pkg::REG_EVICT_THR) ?
	                  {{(32 - skhc_pkg::CNT_W){1'b0}}, thr_q} : '0;
	assign slot_nxt = slot_q + 1'b1;
	assign last_idx = (skhc_pkg::LEN_W'(idx_q) + 1'b1) == pend_len;
	assign restart  = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	skhc_keybuf u_keybuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (s_accept),
		.unit     (s_tdata[15:0]),
		.restart  (restart),
		.rd_idx   (idx_q),
		.hash     (hash),
		.len      (pend_len),
		.overflow (pend_ovf),
		.rd_unit  (pend_unit)
	);

	skhc_store u_store (
		.clk (clk),
		.req (sreq),
		.rsp (srsp)
	);

	always_comb begin
		sreq           = '0;
		sreq.slot_addr = slot_q;
		sreq.value_wd  = handle_q;
		sreq.len_wd    = pend_len;
		sreq.key_addr  = base_q + skhc_pkg::KEY_AW'(idx_q);
		sreq.key_wd    = pend_unit;
		case (state_q)
			ST_CLR: begin
				sreq.slot_addr = clr_cnt_q;
				sreq.valid_we  = 1'b1;
				sreq.valid_wd  = 1'b0;
			end
			ST_INS: begin
				sreq.valid_we = 1'b1;
				sreq.valid_wd = 1'b1;
				sreq.slot_we  = 1'b1;
			end
			ST_CP_WR: begin
				sreq.key_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			after_q       <= AFT_NONE;
			clr_cnt_q     <= '0;
			slot_q        <= '0;
			start_q       <= '0;
			base_q        <= '0;
			idx_q         <= '0;
			used_q        <= '0;
			thr_q         <= skhc_pkg::THR_RESET;
			cmd_q         <= skhc_pkg::CMD_FIND;
			handle_q      <= '0;
			found_q       <= '0;
			empty_q       <= 1'b0;
			res_hit_q     <= 1'b0;
			res_found_q   <= '0;
			res_stored_q  <= 1'b0;
			res_cleared_q <= 1'b0;
			res_rej_q     <= 1'b0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
		end else begin
			if (cfg_wr) begin
				thr_q <= pwdata[skhc_pkg::CNT_W-1:0];
			end
			if (m_tvalid_q && m_tready && !restart) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == skhc_pkg::SLOT_W'(skhc_pkg::SLOTS - 1)) begin
						used_q <= '0;
						case (after_q)
							AFT_RESULT: state_q <= ST_DONE;
							AFT_INSERT: begin
								slot_q  <= start_q;
								state_q <= ST_INS;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_IDLE: begin
					if (s_accept && s_tlast) begin
						cmd_q         <= s_tuser;
						handle_q      <= s_tdata[47:16];
						res_hit_q     <= 1'b0;
						res_found_q   <= '0;
						res_stored_q  <= 1'b0;
						res_cleared_q <= 1'b0;
						res_rej_q     <= 1'b0;
						state_q       <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (cmd_q == skhc_pkg::CMD_CLEAR) begin
						res_cleared_q <= 1'b1;
						after_q       <= AFT_RESULT;
						clr_cnt_q     <= '0;
						state_q       <= ST_CLR;
					end else if (pend_ovf) begin
						res_rej_q <= 1'b1;
						state_q   <= ST_DONE;
					end else begin
						slot_q  <= hash[skhc_pkg::SLOT_W-1:0];
						start_q <= hash[skhc_pkg::SLOT_W-1:0];
						state_q <= ST_P_RD;
					end
				end
				ST_P_RD: begin
					base_q  <= skhc_pkg::KEY_AW'(slot_q * skhc_pkg::MAX_UNITS);
					state_q <= ST_P_CHK;
				end
				ST_P_CHK: begin
					found_q <= srsp.value;
					idx_q   <= '0;
					if (!srsp.valid) begin
						empty_q <= 1'b1;
						state_q <= ST_MISS;
					end else if (srsp.len == pend_len) begin
						state_q <= ST_C_RD;
					end else if (slot_nxt == start_q) begin
						empty_q <= 1'b0;
						state_q <= ST_MISS;
					end else begin
						slot_q  <= slot_nxt;
						state_q <= ST_P_RD;
					end
				end
				ST_C_RD: begin
					state_q <= ST_C_CHK;
				end
				ST_C_CHK: begin
					if (srsp.key != pend_unit) begin
						if (slot_nxt == start_q) begin
							empty_q <= 1'b0;
							state_q <= ST_MISS;
						end else begin
							slot_q  <= slot_nxt;
							state_q <= ST_P_RD;
						end
					end else if (last_idx) begin
						res_hit_q   <= 1'b1;
						res_found_q <= found_q;
						state_q     <= ST_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_C_RD;
					end
				end
				ST_MISS: begin
					if (cmd_q == skhc_pkg::CMD_FIND) begin
						state_q <= ST_DONE;
					end else if (cmd_q == skhc_pkg::CMD_INS_EVICT && used_q >= thr_q) begin
						res_cleared_q <= 1'b1;
						after_q       <= AFT_INSERT;
						clr_cnt_q     <= '0;
						state_q       <= ST_CLR;
					end else if (empty_q) begin
						state_q <= ST_INS;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_INS: begin
					used_q       <= used_q + 1'b1;
					base_q       <= skhc_pkg::KEY_AW'(slot_q * skhc_pkg::MAX_UNITS);
					idx_q        <= '0;
					res_stored_q <= 1'b1;
					state_q      <= ST_CP_RD;
				end
				ST_CP_RD: begin
					state_q <= ST_CP_WR;
				end
				ST_CP_WR: begin
					if (last_idx) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_CP_RD;
					end
				end
				ST_DONE: begin
					if (restart) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'b0, used_q, res_rej_q, res_cleared_q, res_stored_q,
						               res_found_q, res_hit_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTH
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= skhc_pkg::CNT_W'(skhc_pkg::SLOTS))
		else $error("used count beyond table size");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({res_hit_q, res_stored_q, res_rej_q}))
		else $error("more than one outcome flag set");

	a_pend_len: assert property (@(posedge clk) disable iff (!arst_n)
		pend_len <= skhc_pkg::LEN_W'(skhc_pkg::MAX_UNITS))
		else $error("pending length beyond buffer");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside done state");

	a_hit_has_no_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_hit_q |-> !res_cleared_q)
		else $error("hit with table cleared");
`endif

endmodule
